/* rtl/pva_pkg.sv */
package pva_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_QUERY = 2'd1,
        OP_STOP  = 2'd2,
        OP_ENDED = 2'd3
    } op_t;

    typedef enum logic {
        REG_ENABLE = 1'b0,
        REG_COUNT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_EVAL    = 2'd1,
        ST_RESOLVE = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
    } pva_cmd_t;

    localparam int PRI_W   = 8;
    localparam int JOB_W   = 32;
    localparam int EVOICE_W = 4;
    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

endpackage

/* rtl/pva_ctrl.sv */
module pva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pva_pkg::pva_cmd_t cmd
);

    pva_pkg::state_t state_reg;
    pva_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pva_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.eval    = 1'b0;
        cmd.commit  = 1'b0;
        in_ready    = 1'b0;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pva_pkg::ST_EVAL;
                end
            end
            pva_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = pva_pkg::ST_RESOLVE;
            end
            pva_pkg::ST_RESOLVE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_commit_loads_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result word not presented after commit");

    a_eval_then_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pva_pkg::ST_EVAL |=> state_reg == pva_pkg::ST_RESOLVE)
        else $error("evaluation not followed by resolve");

endmodule

/* rtl/pva_datapath.sv */
module pva_datapath #(
    parameter int VOICES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pva_pkg::pva_cmd_t             cmd,
    input  logic                          enable,
    input  logic [pva_pkg::COUNT_W-1:0]   voice_count,
    input  logic [1:0]                    op,
    input  logic [pva_pkg::PRI_W-1:0]     priority_req,
    input  logic [pva_pkg::JOB_W-1:0]     query_id,
    input  logic [pva_pkg::EVOICE_W-1:0]  ended_voice,
    output logic                          granted,
    output logic [pva_pkg::EVOICE_W-1:0]  voice,
    output logic [pva_pkg::JOB_W-1:0]     new_job_id,
    output logic                          active
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LW_RAW = $clog2(VOICES + 1);
    localparam int LW     = (LW_RAW > pva_pkg::COUNT_W) ? LW_RAW : pva_pkg::COUNT_W;
    localparam int PW     = (VIDX_W > pva_pkg::EVOICE_W) ? VIDX_W : pva_pkg::EVOICE_W;

    logic [1:0]                   op_reg;
    logic [pva_pkg::PRI_W-1:0]    pri_reg;
    logic [pva_pkg::JOB_W-1:0]    qid_reg;
    logic [pva_pkg::EVOICE_W-1:0] ended_reg;

    logic                         busy_reg  [VOICES];
    logic                         busy_next [VOICES];
    logic [pva_pkg::PRI_W-1:0]    prio_reg  [VOICES];
    logic [pva_pkg::JOB_W-1:0]    job_reg   [VOICES];

    logic [VOICES-1:0]            free_vec_reg;
    logic [VOICES-1:0]            low_vec_reg;
    logic [VOICES-1:0]            eq_vec_reg;
    logic [VOICES-1:0]            hit_vec_reg;

    logic [pva_pkg::JOB_W-1:0]    job_counter_reg;
    logic [pva_pkg::JOB_W-1:0]    job_counter_next;

    logic                         granted_reg;
    logic [pva_pkg::EVOICE_W-1:0] voice_reg;
    logic [pva_pkg::JOB_W-1:0]    job_out_reg;
    logic                         active_reg;

    logic [LW-1:0]                count_ext;
    logic [LW-1:0]                live_n;
    logic [VOICES-1:0]            lane_live;
    logic [VOICES-1:0]            sel_vec;
    logic [VIDX_W-1:0]            sel_idx;
    logic [PW-1:0]                sel_pad;
    logic                         grant;
    logic                         query_hit;
    logic                         stop_all;
    logic                         end_one;

    assign count_ext = LW'(voice_count);
    assign live_n    = (count_ext > LW'(VOICES)) ? LW'(VOICES) : count_ext;

    always_comb
    begin
        for (int i = 0; i < VOICES; i++)
            lane_live[i] = (LW'(i) < live_n);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            pri_reg   <= priority_req;
            qid_reg   <= query_id;
            ended_reg <= ended_voice;
        end
        if (cmd.eval)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                free_vec_reg[i] <= lane_live[i] && !busy_reg[i];
                low_vec_reg[i]  <= lane_live[i] && (prio_reg[i] < pri_reg);
                eq_vec_reg[i]   <= lane_live[i] && (prio_reg[i] == pri_reg);
                hit_vec_reg[i]  <= lane_live[i] && busy_reg[i] && (job_reg[i] == qid_reg);
            end
        end
    end

    always_comb
    begin
        priority if (|free_vec_reg)
            sel_vec = free_vec_reg;
        else if (|low_vec_reg)
            sel_vec = low_vec_reg;
        else
            sel_vec = eq_vec_reg;

        sel_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (sel_vec[i])
                sel_idx = VIDX_W'(i);
        end
    end

    assign sel_pad   = PW'(sel_idx);
    assign grant     = (op_reg == pva_pkg::OP_ALLOC) && enable && (pri_reg != '0) && (|sel_vec);
    assign query_hit = (op_reg == pva_pkg::OP_QUERY) && enable && (|hit_vec_reg);
    assign stop_all  = (op_reg == pva_pkg::OP_STOP) && enable;
    assign end_one   = (op_reg == pva_pkg::OP_ENDED) && (LW'(ended_reg) < live_n);

    always_comb
    begin
        job_counter_next = job_counter_reg + 1'b1;
        if (job_counter_next == '0)
            job_counter_next = {{(pva_pkg::JOB_W-1){1'b0}}, 1'b1};

        for (int i = 0; i < VOICES; i++)
        begin
            busy_next[i] = busy_reg[i];
            if (stop_all && lane_live[i])
                busy_next[i] = 1'b0;
            if (end_one && (LW'(ended_reg) == LW'(i)))
                busy_next[i] = 1'b0;
            if (grant && (sel_idx == VIDX_W'(i)))
                busy_next[i] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
                busy_reg[i] <= 1'b0;
            job_counter_reg <= '0;
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < VOICES; i++)
                busy_reg[i] <= busy_next[i];
            if (grant)
                job_counter_reg <= job_counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (grant && (sel_idx == VIDX_W'(i)))
                begin
                    prio_reg[i] <= pri_reg;
                    job_reg[i]  <= job_counter_next;
                end
            end
            granted_reg <= grant;
            voice_reg   <= grant ? sel_pad[pva_pkg::EVOICE_W-1:0] : '0;
            job_out_reg <= grant ? job_counter_next : '0;
            active_reg  <= query_hit;
        end
    end

    assign granted    = granted_reg;
    assign voice      = voice_reg;
    assign new_job_id = job_out_reg;
    assign active     = active_reg;

    a_counter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && grant |=> job_counter_reg != '0)
        else $error("job id zero handed out");

    a_counter_steady: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && grant) |=> $stable(job_counter_reg))
        else $error("job counter moved without a grant");

    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && grant |=> busy_reg[$past(sel_idx)])
        else $error("granted voice not marked busy");

endmodule

/* rtl/priority_voice_allocator_core.sv */
// Voice allocator with priority stealing.
// Requests enter on the s_ stream channel; op travels in s_tuser and selects allocate,
// query, stop-all or voice-ended. Every request word yields exactly one result word on
// the m_ stream channel: granted flag, voice index, new job id and query answer.
// Allocate takes the lowest free voice, else the first of lower priority, else the first
// of equal priority, and hands out the next nonzero job id.
// The APB port holds enable (address 0) and voice_count (address 4); write them only
// while no request is in flight.
// A request passes through acceptance, an evaluation state in which every voice is compared in
// parallel against the request, and a resolve state that updates the voice table and
// loads the result register, from which the result is presented. A new request is
// accepted only once the previous one has resolved; the control sequencer sets this order.
// If the receiver stalls, the finished result waits in the output register while the
// next request is still accepted and evaluated; it then holds in resolve until the
// output register is taken.
// Reset frees all voices, clears the job counter, disables the block and sets
// voice_count to 16; no clearing pass is needed.
module priority_voice_allocator_core #(
    parameter int VOICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // priority_req[7:0], query_id[39:8], ended_voice[43:40], zero[47:44]
    input  logic [47:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // granted[0], voice[4:1], new_job_id[36:5], active[37], zero[39:38]
    output logic [39:0] m_tdata
);

    logic                          enable_reg;
    logic [pva_pkg::COUNT_W-1:0]   count_reg;
    logic                          wr_en;
    pva_pkg::reg_idx_t             reg_sel;
    pva_pkg::pva_cmd_t             cmd;

    logic                          granted;
    logic [pva_pkg::EVOICE_W-1:0]  voice;
    logic [pva_pkg::JOB_W-1:0]     new_job_id;
    logic                          active;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = pva_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            count_reg  <= pva_pkg::COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                pva_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                pva_pkg::REG_COUNT:  count_reg  <= pwdata[pva_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            pva_pkg::REG_ENABLE: prdata = {31'b0, enable_reg};
            pva_pkg::REG_COUNT:  prdata = {{(32-pva_pkg::COUNT_W){1'b0}}, count_reg};
            default:             prdata = '0;
        endcase
    end

    pva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    pva_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .enable       (enable_reg),
        .voice_count  (count_reg),
        .op           (s_tuser),
        .priority_req (s_tdata[7:0]),
        .query_id     (s_tdata[39:8]),
        .ended_voice  (s_tdata[43:40]),
        .granted      (granted),
        .voice        (voice),
        .new_job_id   (new_job_id),
        .active       (active)
    );

    assign m_tdata = {2'b00, active, new_job_id, voice, granted};

endmodule
